### hw/rtl/hfst_pkg.sv
// hfst_pkg: shared types and constants for the hot function sample table
// holds the table entry, result record, outcome codes and sequencer states
// depends on nothing
package hfst_pkg;

    localparam int unsigned ID_W    = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned SLOT_W  = 4;

    // request kinds
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [2:0] {
        OUTCOME_IGNORED  = 3'd0,
        OUTCOME_HIT      = 3'd1,
        OUTCOME_INSERTED = 3'd2,
        OUTCOME_REPLACED = 3'd3,
        OUTCOME_READ     = 3'd4
    } outcome_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        outcome_t           outcome;
        logic [SLOT_W-1:0]  slot_index;
        logic [ID_W-1:0]    entry_id;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_COMMIT,
        ST_SWAP,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

### hw/rtl/hfst_if.sv
// hfst_if: request and result channels of the hot function sample table
// valid/ready handshake with the payload fields; no dependencies
interface hfst_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] func_id;
    logic        in_syscall;
    logic        is_native;
    logic [3:0]  read_slot;

    modport source (
        output valid, command, func_id, in_syscall, is_native, read_slot,
        input  ready
    );
    modport sink (
        input  valid, command, func_id, in_syscall, is_native, read_slot,
        output ready
    );
endinterface

interface hfst_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  outcome;
    logic [3:0]  slot_index;
    logic [31:0] entry_id;
    logic [31:0] entry_count;

    modport source (
        output valid, outcome, slot_index, entry_id, entry_count,
        input  ready
    );
    modport sink (
        input  valid, outcome, slot_index, entry_id, entry_count,
        output ready
    );
endinterface

### hw/rtl/hfst_mem.sv
// hfst_mem: slot store, one write and one registered read port per cycle
// per-entry valid flops give the all-empty state straight after reset
// depends on hfst_pkg
module hfst_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IDX_W = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IDX_W-1:0]      rd_addr,
    output hfst_pkg::entry_t      rd_data,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  hfst_pkg::entry_t      wr_data
);

    hfst_pkg::entry_t mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    hfst_pkg::entry_t data_reg;
    logic             rd_valid_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        data_reg <= mem[rd_addr];
    end

    // written flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // an unwritten entry reads as empty
    assign rd_data = rd_valid_reg ? data_reg : '0;

endmodule

### hw/rtl/hot_function_sample_table_core.sv
// hot_function_sample_table_core: count-ordered table of sampled function ids
// scan sequencer around the hfst_mem slot store; depends on hfst_pkg, hfst_if
//
//   channel  dir  modport  carries
//   req      in   sink     command, func_id, in_syscall, is_native, read_slot
//   res      out  source   outcome, slot_index, entry_id, entry_count
//
// a sample walks the store one slot per cycle through the single read port
// up to a matching or empty slot, then calc, commit, a swap if it overtakes, done;
// a full table skips calc; reads step through read and done, ignored samples go to done
// reset empties the table at once through the per-slot valid flops
// one request is in flight at a time; a finished result waits in the output
// register while the next request is taken in, a second one holds the done step
module hot_function_sample_table_core #(
    parameter int unsigned NUM_SLOTS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    hfst_req_if.sink     req,
    hfst_res_if.source   res
);

    localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NUM_SLOTS - 1);

    hfst_pkg::state_t   state_reg, state_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [31:0]        id_reg, id_next;
    logic [3:0]         slot4_reg, slot4_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               swap_ok_reg, swap_ok_next;
    hfst_pkg::entry_t   prev_reg, prev_next;
    hfst_pkg::entry_t   cur_reg, cur_next;
    hfst_pkg::entry_t   new_reg, new_next;
    hfst_pkg::outcome_t outcome_reg, outcome_next;
    hfst_pkg::result_t  result_reg, result_next;
    hfst_pkg::result_t  out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]   rd_addr;
    hfst_pkg::entry_t   rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    hfst_pkg::entry_t   wr_data;
    logic               accept;
    logic               do_swap;

    hfst_mem #(
        .DEPTH (NUM_SLOTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == hfst_pkg::ST_IDLE);
    assign do_swap   = swap_ok_reg && (new_reg.count > prev_reg.count);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hfst_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        id_reg      <= id_next;
        slot4_reg   <= slot4_next;
        rd_ok_reg   <= rd_ok_next;
        swap_ok_reg <= swap_ok_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        new_reg     <= new_next;
        outcome_reg <= outcome_next;
        result_reg  <= result_next;
        out_reg     <= out_next;
    end

    // sequencer: scan, update, write back, serve reads, hand over result
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        id_next        = id_reg;
        slot4_next     = slot4_reg;
        rd_ok_next     = rd_ok_reg;
        swap_ok_next   = swap_ok_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        new_next       = new_reg;
        outcome_next   = outcome_reg;
        result_next    = result_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res.ready;
        rd_addr        = pos_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = new_reg;

        unique case (state_reg)
            hfst_pkg::ST_IDLE:
            begin
                rd_addr = (req.command == hfst_pkg::CMD_READ)
                          ? IDX_W'(req.read_slot) : '0;
                if (accept)
                begin
                    id_next    = req.func_id;
                    slot4_next = req.read_slot;
                    rd_ok_next = (32'(req.read_slot) < NUM_SLOTS);
                    if (req.command == hfst_pkg::CMD_READ)
                    begin
                        state_next = hfst_pkg::ST_READ;
                    end
                    else if (req.func_id == '0 || req.in_syscall || req.is_native)
                    begin
                        result_next = '{hfst_pkg::OUTCOME_IGNORED, '0, '0, '0};
                        state_next  = hfst_pkg::ST_DONE;
                    end
                    else
                    begin
                        pos_next   = '0;
                        state_next = hfst_pkg::ST_SCAN;
                    end
                end
            end

            hfst_pkg::ST_SCAN:
            begin
                // data for pos_reg is back; fetch the next slot meanwhile
                rd_addr = pos_reg + 1'b1;
                if (rd_data.id == '0 || rd_data.id == id_reg)
                begin
                    cur_next   = rd_data;
                    state_next = hfst_pkg::ST_CALC;
                end
                else if (pos_reg == LAST_SLOT)
                begin
                    new_next     = '{id_reg, 32'd1};
                    outcome_next = hfst_pkg::OUTCOME_REPLACED;
                    swap_ok_next = 1'b0;
                    state_next   = hfst_pkg::ST_COMMIT;
                end
                else
                begin
                    prev_next = rd_data;
                    pos_next  = pos_reg + 1'b1;
                end
            end

            hfst_pkg::ST_CALC:
            begin
                // fill an empty slot or bump a saturating count
                if (cur_reg.id == '0)
                begin
                    new_next     = '{id_reg, 32'd1};
                    outcome_next = hfst_pkg::OUTCOME_INSERTED;
                end
                else
                begin
                    new_next.id    = cur_reg.id;
                    new_next.count = (cur_reg.count == '1) ? cur_reg.count
                                                           : cur_reg.count + 32'd1;
                    outcome_next   = hfst_pkg::OUTCOME_HIT;
                end
                swap_ok_next = (pos_reg != '0);
                state_next   = hfst_pkg::ST_COMMIT;
            end

            hfst_pkg::ST_COMMIT:
            begin
                wr_en   = 1'b1;
                wr_data = new_reg;
                if (do_swap)
                begin
                    wr_addr     = pos_reg - 1'b1;
                    result_next = '{outcome_reg, 4'(pos_reg - 1'b1),
                                    new_reg.id, new_reg.count};
                    state_next  = hfst_pkg::ST_SWAP;
                end
                else
                begin
                    wr_addr     = pos_reg;
                    result_next = '{outcome_reg, 4'(pos_reg), new_reg.id, new_reg.count};
                    state_next  = hfst_pkg::ST_DONE;
                end
            end

            hfst_pkg::ST_SWAP:
            begin
                // move the overtaken entry down one slot
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = prev_reg;
                state_next = hfst_pkg::ST_DONE;
            end

            hfst_pkg::ST_READ:
            begin
                if (rd_ok_reg)
                begin
                    result_next = '{hfst_pkg::OUTCOME_READ, slot4_reg,
                                    rd_data.id, rd_data.count};
                end
                else
                begin
                    result_next = '{hfst_pkg::OUTCOME_READ, slot4_reg, '0, '0};
                end
                state_next = hfst_pkg::ST_DONE;
            end

            hfst_pkg::ST_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_next       = result_reg;
                    out_valid_next = 1'b1;
                    state_next     = hfst_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = hfst_pkg::ST_IDLE;
            end
        endcase
    end

    // result channel
    assign res.valid       = out_valid_reg;
    assign res.outcome     = out_reg.outcome;
    assign res.slot_index  = out_reg.slot_index;
    assign res.entry_id    = out_reg.entry_id;
    assign res.entry_count = out_reg.entry_count;

    // checks
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != hfst_pkg::ST_IDLE)
        else $error("request taken but sequencer stayed idle");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hfst_pkg::ST_SCAN || state_reg == hfst_pkg::ST_IDLE) |-> !wr_en)
        else $error("slot store written outside the update steps");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hfst_pkg::ST_SCAN |-> 32'(pos_reg) < NUM_SLOTS)
        else $error("scan position beyond the table");

    a_swap_not_front: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hfst_pkg::ST_COMMIT && do_swap) |-> pos_reg != '0)
        else $error("swap requested at the front slot");

    a_swap_follows_commit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hfst_pkg::ST_SWAP |-> $past(state_reg) == hfst_pkg::ST_COMMIT)
        else $error("swap step entered without a commit");

endmodule
